@@ hdl/mlr_pkg.sv @@
// package for the midpoint line rasterizer: widths, codes and types
package mlr_pkg;

    localparam int COORD_W  = 10;
    localparam int DELTA_W  = 11;
    localparam int ERR_W    = 13;
    localparam int COLOR_W  = 4;
    localparam int HALF_SPAN = 320;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // request kinds carried on tuser
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        SLOPE_SHALLOW_POS = 2'd0,
        SLOPE_STEEP_POS   = 2'd1,
        SLOPE_SHALLOW_NEG = 2'd2,
        SLOPE_STEEP_NEG   = 2'd3
    } t_slope_class;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } t_pixel;

endpackage

@@ hdl/midpoint_line_rasterizer.sv @@
// midpoint line rasterizer: start and step requests in, each gives at most one screen pixel
// an item goes into the input register, then its pixel, if any, into the result register
// throughput: one item per cycle unless output stalls; each item updates the line state
// (cursor, error, step count) by one add, compare and increment, and the next item uses it
// an advance request with no active line gives no result
// reset (i_rst_n low, synchronous) empties both registers and leaves no line active
module midpoint_line_rasterizer
    import mlr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_start[9:0], y_start[19:10], x_end[29:20], y_end[39:30], pen_color[43:40], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_x[9:0], pixel_y[19:10], pixel_color[23:20]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // last_pixel
    output logic                  m_axis_tlast
);

    // input register
    logic                  r_in_valid;
    logic [IN_DATA_W-1:0]  r_in_data;
    logic                  r_in_req;

    // line state
    logic                  r_active;
    logic [COORD_W-1:0]    r_cur_x;
    logic [COORD_W-1:0]    r_cur_y;
    logic [ERR_W-1:0]      r_err;
    logic [COORD_W-1:0]    r_major;
    logic [COORD_W-1:0]    r_minor;
    logic [COORD_W-1:0]    r_steps;
    t_slope_class          r_class;
    logic [COLOR_W-1:0]    r_color;

    // result register
    logic                  r_out_valid;
    t_pixel                r_out;

    logic                  proc_fire;
    logic                  proc_emit;

    // fields of the registered item
    logic [COORD_W-1:0]    xs, ys, xe, ye;
    logic [COLOR_W-1:0]    pen;

    // start path
    logic signed [DELTA_W-1:0] dx, dy;
    logic [DELTA_W-1:0]    ndx, ndy;
    logic [COORD_W-1:0]    adx, ady;
    logic [COORD_W-1:0]    sx1, sy1, sx2, sy2;
    logic                  steep_s, same_dir, take_end;
    t_slope_class          class_s;
    logic [COORD_W-1:0]    major_s, minor_s;
    logic [COORD_W-1:0]    start_x, start_y;
    logic [ERR_W-1:0]      err_s;

    // advance path
    logic                  steep_a, diag;
    logic [ERR_W-1:0]      err_a;
    logic [COORD_W-1:0]    adv_x, adv_y, steps_a;

    // next state
    logic                  n_active;
    logic [COORD_W-1:0]    n_cur_x, n_cur_y, n_major, n_minor, n_steps;
    logic [ERR_W-1:0]      n_err;
    t_slope_class          n_class;
    logic [COLOR_W-1:0]    n_color;

    // the stage works whenever the result register is free or being emptied
    assign proc_fire     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc_fire;
    assign proc_emit     = (r_in_req == REQ_START) || r_active;

    assign xs  = r_in_data[9:0];
    assign ys  = r_in_data[19:10];
    assign xe  = r_in_data[29:20];
    assign ye  = r_in_data[39:30];
    assign pen = r_in_data[43:40];

    // ---------------- start of a new line ----------------
    always_comb begin
        // screen deltas: y is flipped, so dy is y_start - y_end
        dx  = $signed({xe[COORD_W-1], xe}) - $signed({xs[COORD_W-1], xs});
        dy  = $signed({ys[COORD_W-1], ys}) - $signed({ye[COORD_W-1], ye});
        ndx = -dx;
        ndy = -dy;
        adx = dx[DELTA_W-1] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
        ady = dy[DELTA_W-1] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];

        // screen coordinates, wrapping modulo the coordinate range
        sx1 = COORD_W'(HALF_SPAN) + xs;
        sy1 = COORD_W'(HALF_SPAN) - ys;
        sx2 = COORD_W'(HALF_SPAN) + xe;
        sy2 = COORD_W'(HALF_SPAN) - ye;

        same_dir = (dy == '0) || ((dx > 0) == (dy > 0));
        if (dx == '0) begin
            // vertical line or single point
            steep_s = 1'b1;
            class_s = (dy > 0) ? SLOPE_STEEP_POS : SLOPE_STEEP_NEG;
        end else begin
            steep_s = (ady >= adx);
            if (same_dir) begin
                class_s = steep_s ? SLOPE_STEEP_POS : SLOPE_SHALLOW_POS;
            end else begin
                class_s = steep_s ? SLOPE_STEEP_NEG : SLOPE_SHALLOW_NEG;
            end
        end

        // always draw from the smaller coordinate of the major axis
        if (steep_s) begin
            take_end = dy[DELTA_W-1];
            major_s  = ady;
            minor_s  = adx;
        end else begin
            take_end = dx[DELTA_W-1];
            major_s  = adx;
            minor_s  = ady;
        end
        start_x = take_end ? sx2 : sx1;
        start_y = take_end ? sy2 : sy1;

        // midpoint error scaled by two: 2*minor - major
        err_s = {2'b00, minor_s, 1'b0} - {3'b000, major_s};
    end

    // ---------------- one step along the line ----------------
    always_comb begin
        steep_a = (r_class == SLOPE_STEEP_POS) || (r_class == SLOPE_STEEP_NEG);
        // a tie goes diagonal on steep lines only
        if (steep_a) begin
            diag = !r_err[ERR_W-1];
        end else begin
            diag = !r_err[ERR_W-1] && (r_err != '0);
        end

        err_a = r_err + {2'b00, r_minor, 1'b0};
        if (diag) begin
            err_a = err_a - {2'b00, r_major, 1'b0};
        end

        adv_x = r_cur_x;
        adv_y = r_cur_y;
        if (steep_a) begin
            adv_y = r_cur_y + 1'b1;
        end else begin
            adv_x = r_cur_x + 1'b1;
        end
        if (diag) begin
            case (r_class)
                SLOPE_SHALLOW_POS: adv_y = adv_y + 1'b1;
                SLOPE_STEEP_POS:   adv_x = adv_x + 1'b1;
                SLOPE_SHALLOW_NEG: adv_y = adv_y - 1'b1;
                default:           adv_x = adv_x - 1'b1;
            endcase
        end
        steps_a = r_steps - 1'b1;
    end

    // ---------------- next line state ----------------
    always_comb begin
        n_active = r_active;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_err    = r_err;
        n_major  = r_major;
        n_minor  = r_minor;
        n_steps  = r_steps;
        n_class  = r_class;
        n_color  = r_color;
        if (proc_fire) begin
            if (r_in_req == REQ_START) begin
                // a start abandons any line still in progress
                n_active = (major_s != '0);
                n_cur_x  = start_x;
                n_cur_y  = start_y;
                n_err    = err_s;
                n_major  = major_s;
                n_minor  = minor_s;
                n_steps  = major_s;
                n_class  = class_s;
                n_color  = pen;
            end else if (r_active) begin
                n_active = (steps_a != '0);
                n_cur_x  = adv_x;
                n_cur_y  = adv_y;
                n_err    = err_a;
                n_steps  = steps_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (proc_fire) begin
                r_out_valid <= proc_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_active <= n_active;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_req  <= s_axis_tuser;
        end
        r_cur_x <= n_cur_x;
        r_cur_y <= n_cur_y;
        r_err   <= n_err;
        r_major <= n_major;
        r_minor <= n_minor;
        r_steps <= n_steps;
        r_class <= n_class;
        r_color <= n_color;
        if (proc_fire && proc_emit) begin
            r_out.pixel_x     <= n_cur_x;
            r_out.pixel_y     <= n_cur_y;
            r_out.pixel_color <= n_color;
            r_out.last_pixel  <= !n_active;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.pixel_color, r_out.pixel_y, r_out.pixel_x};
    assign m_axis_tlast  = r_out.last_pixel;

endmodule

@@ tb/tb_midpoint_line_rasterizer.sv @@
// self-checking testbench for the midpoint line rasterizer: directed table, random lines, pixel checks
`timescale 1ns / 100ps

module tb_midpoint_line_rasterizer
    import mlr_pkg::*;
();

    // run shape
    localparam int PLAN_ROWS     = 26;
    localparam int RANDOM_PIXELS = 1950;
    localparam int STEADY_FROM   = 600;   // no idling on either side for this stretch of pixels
    localparam int STEADY_TO     = 800;
    localparam int PAUSE_AT      = 1400;  // sender waits for the pipe to empty here
    localparam int HOLD_AT       = 1000;  // receiver holds off for a long stretch here
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 500000;

    // one row of the directed table; expected pixel typed in only where obvious
    typedef struct packed {
        logic              req;
        logic signed [9:0] xs;
        logic signed [9:0] ys;
        logic signed [9:0] xe;
        logic signed [9:0] ye;
        logic [3:0]        col;
        bit                typed;
        bit                has_pixel;
        t_pixel            pixel;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = REQ_START;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // line state of the predictor
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    int                 err_acc;
    int                 run_major;
    int                 run_minor;
    logic [COORD_W-1:0] steps_to_go;
    t_slope_class       run_class;
    logic [COLOR_W-1:0] run_color;
    bit                 run_live;

    t_pixel    expected_pixels[$];
    t_plan_row plan_rows[PLAN_ROWS];
    int        pixels_planned = 0;
    int        pixels_seen = 0;
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        steady_flow = 1'b0;

    midpoint_line_rasterizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // clear the predictor to its after-reset state
    function automatic void clear_line_state();
        cur_x       = '0;
        cur_y       = '0;
        err_acc     = 0;
        run_major   = 0;
        run_minor   = 0;
        steps_to_go = '0;
        run_class   = SLOPE_SHALLOW_POS;
        run_color   = '0;
        run_live    = 1'b0;
    endfunction

    // predictor: apply one accepted item, return 1 and the pixel if one comes out
    function automatic bit predict_pixel(input logic req, input logic signed [9:0] xs,
                                         input logic signed [9:0] ys,
                                         input logic signed [9:0] xe,
                                         input logic signed [9:0] ye,
                                         input logic [3:0] col, output t_pixel pix);
        int x1, y1, x2, y2, dx, dy, adx, ady, sx, sy;
        bit steep, same, diag;
        pix = '0;
        if (req == REQ_START) begin
            // centred coordinates to screen, y flipped to point down
            x1 = HALF_SPAN + int'(xs);
            y1 = HALF_SPAN - int'(ys);
            x2 = HALF_SPAN + int'(xe);
            y2 = HALF_SPAN - int'(ye);
            dx = x2 - x1;
            dy = y2 - y1;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            sx = x1;
            sy = y1;
            if (dx == 0) begin
                // vertical or single point, always steep
                run_class = (dy > 0) ? SLOPE_STEEP_POS : SLOPE_STEEP_NEG;
                steep = 1'b1;
            end else begin
                same = (dy == 0) || ((dx > 0) == (dy > 0));
                steep = (ady >= adx);
                if (same) run_class = steep ? SLOPE_STEEP_POS : SLOPE_SHALLOW_POS;
                else run_class = steep ? SLOPE_STEEP_NEG : SLOPE_SHALLOW_NEG;
            end
            // start from the end with the smaller major coordinate
            if (steep) begin
                if (dy < 0) begin
                    sx = x2;
                    sy = y2;
                end
                run_major = ady;
                run_minor = adx;
            end else begin
                if (dx < 0) begin
                    sx = x2;
                    sy = y2;
                end
                run_major = adx;
                run_minor = ady;
            end
            cur_x       = COORD_W'(sx);
            cur_y       = COORD_W'(sy);
            err_acc     = 2 * run_minor - run_major;
            steps_to_go = COORD_W'(run_major);
            run_color   = col;
            run_live    = (steps_to_go != 0);
        end else begin
            // advance with no line in progress is dropped
            if (!run_live) return 1'b0;
            steep = run_class[0];
            diag = steep ? (err_acc >= 0) : (err_acc > 0);
            if (diag) err_acc += 2 * run_minor - 2 * run_major;
            else err_acc += 2 * run_minor;
            if (steep) cur_y = cur_y + 1'b1;
            else cur_x = cur_x + 1'b1;
            if (diag) begin
                case (run_class)
                    SLOPE_SHALLOW_POS: cur_y = cur_y + 1'b1;
                    SLOPE_STEEP_POS:   cur_x = cur_x + 1'b1;
                    SLOPE_SHALLOW_NEG: cur_y = cur_y - 1'b1;
                    default:           cur_x = cur_x - 1'b1;
                endcase
            end
            steps_to_go = steps_to_go - 1'b1;
            if (steps_to_go == 0) run_live = 1'b0;
        end
        pix.pixel_x     = cur_x;
        pix.pixel_y     = cur_y;
        pix.pixel_color = run_color;
        pix.last_pixel  = !run_live;
        return 1'b1;
    endfunction

    // offer one item after a random gap and hold it until taken; update the expectations
    task automatic offer_request(input logic req, input logic signed [9:0] xs,
                                 input logic signed [9:0] ys, input logic signed [9:0] xe,
                                 input logic signed [9:0] ye, input logic [3:0] col,
                                 input bit typed, input bit typed_has, input t_pixel typed_pix);
        int gap;
        t_pixel pix;
        bit produced;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {4'b0, col, ye, xe, ys, xs};
        // tready is settled by the falling edge; the item is taken at the next rising edge
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        produced = predict_pixel(req, xs, ys, xe, ye, col, pix);
        if (typed) begin
            if (typed_has) begin
                expected_pixels.push_back(typed_pix);
                pixels_planned++;
            end
        end else if (produced) begin
            expected_pixels.push_back(pix);
            pixels_planned++;
        end
    endtask

    // endpoint anywhere on the span, ends of the range favoured
    function automatic logic signed [9:0] pick_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return -10'sd320;
        if (r == 1) return 10'sd320;
        return 10'(int'($urandom_range(0, 640)) - 320);
    endfunction

    // endpoint near another one, kept on the span
    function automatic logic signed [9:0] near_coord(input logic signed [9:0] c, input int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v > 320) v = 320;
        if (v < -320) v = -320;
        return 10'(v);
    endfunction

    // one random line: mostly a start and its full run of advances, sometimes cut short,
    // overrun, or a stray advance on its own
    task automatic random_line();
        logic signed [9:0] xs, ys, xe, ye;
        logic [3:0] col;
        int kind, size_pick, span, n_adv, mode, k;
        kind = $urandom_range(0, 99);
        col = 4'($urandom_range(0, 15));
        if (kind < 8) begin
            offer_request(REQ_ADVANCE, 10'($urandom), 10'($urandom), 10'($urandom),
                          10'($urandom), col, 1'b0, 1'b0, '0);
            return;
        end
        size_pick = $urandom_range(0, 99);
        xs = pick_coord();
        ys = pick_coord();
        if (size_pick == 0) begin
            // rare full-span line
            xe = pick_coord();
            ye = pick_coord();
        end else begin
            span = (size_pick < 15) ? 40 : 6;
            xe = near_coord(xs, span);
            ye = near_coord(ys, span);
            // single points, horizontals and verticals now and then
            if ($urandom_range(0, 9) == 0) xe = xs;
            if ($urandom_range(0, 9) == 0) ye = ys;
        end
        offer_request(REQ_START, xs, ys, xe, ye, col, 1'b0, 1'b0, '0);
        n_adv = run_major;
        mode = $urandom_range(0, 9);
        if (mode == 0) n_adv = $urandom_range(0, run_major);            // abandoned early
        else if (mode == 1) n_adv = run_major + $urandom_range(1, 3);   // advances past the end
        for (k = 0; k < n_adv; k++) begin
            // unused fields carry noise on advances
            offer_request(REQ_ADVANCE, 10'($urandom), 10'($urandom), 10'($urandom),
                          10'($urandom), 4'($urandom), 1'b0, 1'b0, '0);
        end
    endtask

    // compare one received pixel with the oldest one expected
    function automatic void check_pixel(input t_pixel got);
        t_pixel want;
        if (expected_pixels.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d color=%0d last=%0d",
                   got.pixel_x, got.pixel_y, got.pixel_color, got.last_pixel);
            mismatch_count++;
            return;
        end
        want = expected_pixels.pop_front();
        if (got.pixel_x !== want.pixel_x) begin
            $error("pixel_x expected %0d actual %0d", want.pixel_x, got.pixel_x);
            mismatch_count++;
        end
        if (got.pixel_y !== want.pixel_y) begin
            $error("pixel_y expected %0d actual %0d", want.pixel_y, got.pixel_y);
            mismatch_count++;
        end
        if (got.pixel_color !== want.pixel_color) begin
            $error("pixel_color expected %0d actual %0d", want.pixel_color, got.pixel_color);
            mismatch_count++;
        end
        if (got.last_pixel !== want.last_pixel) begin
            $error("last_pixel expected %0d actual %0d", want.last_pixel, got.last_pixel);
            mismatch_count++;
        end
    endfunction

    // receiver: random stall before each pixel, one long hold-off to back the block up
    initial begin : pixel_sink
        int stall;
        t_pixel got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 10);
            if (pixels_seen == HOLD_AT) stall = HOLD_CYCLES;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge i_clk); while (!m_axis_tvalid);
            got.pixel_x     = m_axis_tdata[9:0];
            got.pixel_y     = m_axis_tdata[19:10];
            got.pixel_color = m_axis_tdata[23:20];
            got.last_pixel  = m_axis_tlast;
            @(posedge i_clk);
            check_pixel(got);
            pixels_seen++;
        end
    end

    // sender: reset, directed table, random lines, drain, verdict
    initial begin : line_requests
        int row, base;
        bit paused;
        paused = 1'b0;
        clear_line_state();
        // directed table: idle advances, single point, span extremes, both directions,
        // horizontal, vertical up and down, decision ties in shallow and steep classes,
        // restart while a line is in progress
        plan_rows = '{
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b1, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_START,      0,    0,    0,    0,  5, 1'b1, 1'b1, '{320, 320,  5, 1}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b1, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_START,   -320,  320,  320, -320, 15, 1'b1, 1'b1, '{  0,   0, 15, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_START,    320, -320, -320,  320,  0, 1'b1, 1'b1, '{  0,   0,  0, 0}},
            '{REQ_START,      2,    0,   -2,    0,  3, 1'b1, 1'b1, '{318, 320,  3, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b1, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_START,      0,    2,    0,   -1,  6, 1'b1, 1'b1, '{320, 318,  6, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_START,      0,   -1,    0,    1,  9, 1'b1, 1'b1, '{320, 319,  9, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_START,      0,    0,    4,    2, 10, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_START,      0,    0,    4,   -2, 11, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_START,      0,    0,   -2,   -4, 12, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}},
            '{REQ_ADVANCE,    0,    0,    0,    0,  0, 1'b0, 1'b0, '{  0,   0,  0, 0}}
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < PLAN_ROWS; row++) begin
            offer_request(plan_rows[row].req, plan_rows[row].xs, plan_rows[row].ys,
                          plan_rows[row].xe, plan_rows[row].ye, plan_rows[row].col,
                          plan_rows[row].typed, plan_rows[row].has_pixel,
                          plan_rows[row].pixel);
        end

        base = pixels_planned;
        while (pixels_planned < base + RANDOM_PIXELS) begin
            steady_flow = (pixels_planned >= base + STEADY_FROM) &&
                          (pixels_planned < base + STEADY_TO);
            if (!paused && pixels_planned >= base + PAUSE_AT) begin
                // sender goes quiet until every pixel in flight is out
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (expected_pixels.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            random_line();
        end
        steady_flow = 1'b0;

        // drain, then run on for DRAIN_CYCLES to catch anything stray
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
